/* rtl/core/i2c_bit_level_master_core_defines.svh */
// Assertion macros used by the I2C master core checker.
`ifndef I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define I2CM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cm same-cycle check failed");

// Next-cycle implication, disabled in reset
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cm next-cycle check failed");

`endif

/* rtl/core/i2cm_pkg.sv */
// Types and constants of the I2C bit-level master core.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Command codes; the top code means no command is running
   typedef enum logic [2:0] {
      CMD_START   = 3'd0,
      CMD_STOP    = 3'd1,
      CMD_WRITE   = 3'd2,
      CMD_READ    = 3'd3,
      CMD_WAITACK = 3'd4,
      CMD_ACK     = 3'd5,
      CMD_NACK    = 3'd6,
      CMD_IDLE    = 3'd7
   } cmd_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_BIT_PHASE   = 2'd0;
   localparam logic [1:0] CSR_COND_PHASE  = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT = 2'd2;

   localparam logic [7:0]  BIT_PHASE_RESET   = 8'd2;
   localparam logic [7:0]  COND_PHASE_RESET  = 8'd4;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd250;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   // Input word
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] kind;
      logic [7:0] byte_in;
      logic       sda_in;
   } req_type;

   // Result word
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_missing;
   } rsp_type;

   // Configuration registers
   typedef struct packed {
      logic [7:0]  bit_phase_ticks;
      logic [7:0]  cond_phase_ticks;
      logic [15:0] ack_timeout;
   } cfg_type;

   // Sequencer state
   typedef struct packed {
      cmd_type     active_cmd;
      logic [7:0]  phase_count;
      logic [2:0]  step_index;
      logic [3:0]  bit_count;
      logic [7:0]  shift_reg;
      logic [15:0] timeout_count;
      logic        scl;
      logic        sda;
      logic        drv;
      logic        ack_flag;
      logic [7:0]  last_read;
   } core_state_type;

endpackage

/* rtl/core/i2cm_step.sv */
// Next-state logic of the I2C sequencer for one tick.
`timescale 1ns / 1ps

module i2cm_step (
   input  i2cm_pkg::core_state_type state,
   input  i2cm_pkg::cfg_type        cfg,
   input  i2cm_pkg::req_type        req,
   output i2cm_pkg::core_state_type state_next,
   output logic                     done
);
   import i2cm_pkg::*;

   // Begin step s of the running command: set pins, load phase length
   function automatic core_state_type enter_step(core_state_type st, logic [2:0] s,
                                                 logic [7:0] bit_len, logic [7:0] cond_len);
      core_state_type r;
      r = st;
      r.step_index = s;
      unique case (st.active_cmd)
         CMD_START: begin
            r.phase_count = cond_len;
            if (s == 3'd0) begin
               r.drv = 1'b1;
               r.scl = 1'b1;
               r.sda = 1'b1;
            end else begin
               r.sda = 1'b0;
            end
         end
         CMD_STOP: begin
            r.phase_count = cond_len;
            if (s == 3'd0) begin
               r.drv = 1'b1;
               r.scl = 1'b0;
               r.sda = 1'b0;
            end else if (s == 3'd1) begin
               r.scl = 1'b1;
            end else begin
               r.sda = 1'b1;
            end
         end
         CMD_WRITE: begin
            r.phase_count = bit_len;
            if (s == 3'd0) begin
               r.drv       = 1'b1;
               r.scl       = 1'b0;
               r.sda       = st.shift_reg[7];
               r.shift_reg = {st.shift_reg[6:0], 1'b0};
            end else begin
               r.scl = (s == 3'd1);
            end
         end
         CMD_READ: begin
            r.phase_count = bit_len;
            if (s == 3'd0) begin
               r.drv = 1'b0;
               r.scl = 1'b0;
            end else begin
               r.scl = 1'b1;
            end
         end
         CMD_WAITACK: begin
            r.phase_count = bit_len;
            if (s == 3'd0) begin
               r.drv = 1'b0;
               r.sda = 1'b1;
            end else if (s == 3'd1) begin
               r.scl = 1'b1;
            end
         end
         default: begin
            // ack / nack
            r.phase_count = bit_len;
            if (s == 3'd0) begin
               r.drv = 1'b1;
               r.scl = 1'b0;
               r.sda = (st.active_cmd == CMD_NACK);
            end else begin
               r.scl = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   logic [7:0] bit_len;
   logic [7:0] cond_len;

   // A zero phase register gives one-tick phases
   assign bit_len  = (cfg.bit_phase_ticks  == 8'd0) ? 8'd1 : cfg.bit_phase_ticks;
   assign cond_len = (cfg.cond_phase_ticks == 8'd0) ? 8'd1 : cfg.cond_phase_ticks;

   always_comb begin
      core_state_type n;
      logic [3:0]     bit_count_inc;
      n             = state;
      done          = 1'b0;
      bit_count_inc = state.bit_count + 4'd1;

      if (state.active_cmd == CMD_IDLE) begin
         // idle: load a new command
         if (req.cmd_valid && (cmd_type'(req.kind) != CMD_IDLE)) begin
            n.active_cmd = cmd_type'(req.kind);
            n.bit_count  = 4'd0;
            case (cmd_type'(req.kind))
               CMD_WRITE:   n.shift_reg     = req.byte_in;
               CMD_READ:    n.shift_reg     = 8'd0;
               CMD_WAITACK: n.timeout_count = 16'd0;
               default:     ;
            endcase
            n = enter_step(n, 3'd0, bit_len, cond_len);
         end
      end else if ((state.active_cmd == CMD_WAITACK) && (state.step_index >= 3'd2)) begin
         // poll SDA for acknowledge
         if (!req.sda_in) begin
            n.ack_flag = 1'b0;
            n.scl      = 1'b0;
            done       = 1'b1;
         end else if (state.timeout_count >= cfg.ack_timeout) begin
            n.ack_flag = 1'b1;
            n.scl      = 1'b0;
            done       = 1'b1;
         end else begin
            n.timeout_count = state.timeout_count + 16'd1;
         end
      end else begin
         // count down the phase, then step on
         if (n.phase_count != 8'd0) n.phase_count = n.phase_count - 8'd1;
         if (n.phase_count == 8'd0) begin
            case (state.active_cmd)
               CMD_START: begin
                  if (state.step_index == 3'd0) begin
                     n = enter_step(n, 3'd1, bit_len, cond_len);
                  end else begin
                     n.scl = 1'b0;
                     done  = 1'b1;
                  end
               end
               CMD_STOP: begin
                  if (state.step_index < 3'd2) begin
                     n = enter_step(n, state.step_index + 3'd1, bit_len, cond_len);
                  end else begin
                     done = 1'b1;
                  end
               end
               CMD_WRITE: begin
                  if (state.step_index < 3'd2) begin
                     n = enter_step(n, state.step_index + 3'd1, bit_len, cond_len);
                  end else begin
                     n.bit_count = bit_count_inc;
                     if (bit_count_inc < BITS_PER_BYTE) begin
                        n = enter_step(n, 3'd0, bit_len, cond_len);
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               CMD_READ: begin
                  if (state.step_index == 3'd0) begin
                     n = enter_step(n, 3'd1, bit_len, cond_len);
                  end else begin
                     n.shift_reg = {state.shift_reg[6:0], req.sda_in};
                     n.bit_count = bit_count_inc;
                     if (bit_count_inc < BITS_PER_BYTE) begin
                        n = enter_step(n, 3'd0, bit_len, cond_len);
                     end else begin
                        n.scl       = 1'b0;
                        n.last_read = n.shift_reg;
                        done        = 1'b1;
                     end
                  end
               end
               CMD_WAITACK: begin
                  n = enter_step(n, state.step_index + 3'd1, bit_len, cond_len);
               end
               default: begin
                  // ack / nack
                  if (state.step_index == 3'd0) begin
                     n = enter_step(n, 3'd1, bit_len, cond_len);
                  end else begin
                     n.scl = 1'b0;
                     done  = 1'b1;
                  end
               end
            endcase
         end
      end

      if (done) n.active_cmd = CMD_IDLE;
      state_next = n;
   end

endmodule

/* rtl/core/i2c_bit_level_master_core.sv */
// Top level of the tick-driven I2C bit-level master.
`timescale 1ns / 1ps

// Each accepted req word is one bus tick, optionally carrying a command
// (start, stop, write byte, read byte, wait ack, ack, nack). The sequencer
// state is updated in the accepting cycle; pin levels, busy/done, read
// byte and ack-missing flag appear in the rsp word in the cycle after,
// held in an output register. One tick is taken every cycle while rsp
// words are being taken; req_ready drops only while a rsp word stalls.
// User must write phase lengths, ack timeout (reset 2, 4, 250) via csr
// port only while no command runs; the block does not enforce this.
module i2c_bit_level_master_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i2cm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import i2cm_pkg::*;

   core_state_type state_ff, state_in;
   cfg_type        cfg_ff, cfg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic           req_accept;
   logic           step_done;

   // Tick sequencer
   i2cm_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .req        (req_data),
      .state_next (state_in),
      .done       (step_done)
   );

   // Handshake: take a word whenever the output register frees up
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Result word from the new state
   always_comb begin
      rsp_data_in.scl_level   = state_in.scl;
      rsp_data_in.sda_level   = state_in.sda;
      rsp_data_in.sda_drive   = state_in.drv;
      rsp_data_in.busy_res    = (state_in.active_cmd != CMD_IDLE);
      rsp_data_in.done_res    = step_done;
      rsp_data_in.read_data   = state_in.last_read;
      rsp_data_in.ack_missing = state_in.ack_flag;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BIT_PHASE:   cfg_in.bit_phase_ticks  = csr_wdata[7:0];
            CSR_COND_PHASE:  cfg_in.cond_phase_ticks = csr_wdata[7:0];
            CSR_ACK_TIMEOUT: cfg_in.ack_timeout      = csr_wdata;
            default:         ;
         endcase
      end
   end

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.active_cmd    <= CMD_IDLE;
         state_ff.phase_count   <= 8'd0;
         state_ff.step_index    <= 3'd0;
         state_ff.bit_count     <= 4'd0;
         state_ff.shift_reg     <= 8'd0;
         state_ff.timeout_count <= 16'd0;
         state_ff.scl           <= 1'b1;
         state_ff.sda           <= 1'b1;
         state_ff.drv           <= 1'b1;
         state_ff.ack_flag      <= 1'b0;
         state_ff.last_read     <= 8'd0;
         cfg_ff.bit_phase_ticks  <= BIT_PHASE_RESET;
         cfg_ff.cond_phase_ticks <= COND_PHASE_RESET;
         cfg_ff.ack_timeout      <= ACK_TIMEOUT_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (req_accept) state_ff <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (req_accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/i2cm_checker.sv */
// Port-level checks for the I2C master core, bound to the top level.
`timescale 1ns / 1ps
`include "i2c_bit_level_master_core_defines.svh"

module i2cm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   // A stalled result word holds
   `I2CM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Every accepted tick yields a result word next cycle
   `I2CM_ASSERT_NEXT(a_tick_result, clock, reset, req_valid && req_ready, rsp_valid)

   // No new tick while the result register is stalled
   `I2CM_ASSERT_NOW(a_backpressure, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // A finishing command leaves the sequencer idle
   `I2CM_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res)

endmodule

bind i2c_bit_level_master_core i2cm_checker u_checker (.*);
